@@ hw/rtl/round_robin_process_scheduler_macros.svh @@
// assertion helpers shared by the scheduler
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RRPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled during reset
`define RRPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

@@ hw/rtl/rrps_pkg.sv @@
package rrps_pkg;

  // request opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_SERVED   = 3'd0,
    ST_FINISHED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_ADDED    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] need_time;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] process_id;
    logic [7:0] run_time;
    logic [7:0] need_time_out;
    logic       all_done;
  } out_res_t;

endpackage

@@ hw/rtl/round_robin_process_scheduler.sv @@
// round-robin time-slice scheduler over a table of process slots
// a request passes through slot read and execute before its result is registered; execute waits for the output register
// one request at a time: no new request is accepted until the read-modify-write of its slot memory entry completes
// a result waiting at the output does not block acceptance of the next request
// reset (rst_n low, synchronous): no live slot, slot 0 searched first, no slot handed out;
// the slot memory itself is not cleared, every slot is written when it is added
`include "round_robin_process_scheduler_macros.svh"

module round_robin_process_scheduler
  import rrps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_WIDTH    = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int TW     = TIME_WIDTH;

  // sequencer: accept, read slot memory, execute and write back
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EX   = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [MAX_PROCESSES-1:0]   live_r, live_nxt;
  logic [SLOT_W-1:0]          last_r, last_nxt;
  logic [CNT_W-1:0]           next_slot_r, next_slot_nxt;

  // captured request
  logic                       op_r;
  logic [TW-1:0]              need_r;
  logic [SLOT_W-1:0]          slot_r;
  logic                       found_r;

  // slot memory: {need, run} per slot, registered read
  logic [2*TW-1:0]            mem [MAX_PROCESSES];
  logic [2*TW-1:0]            rdata_r;
  logic [2*TW-1:0]            wdata;
  logic                       mem_we;
  logic [TW-1:0]              rd_need;
  logic [TW-1:0]              rd_run;
  logic [TW-1:0]              run_inc;

  // output register
  logic                       out_valid_r;
  out_res_t                   out_data_r;
  out_res_t                   res;

  logic                       in_acc;
  logic                       ex_go;
  logic                       full;
  logic                       finished;

  // rotating search
  logic [MAX_PROCESSES-1:0]   above;
  logic [MAX_PROCESSES-1:0]   cand;
  logic [MAX_PROCESSES-1:0]   first_oh;
  logic [SLOT_W-1:0]          search_idx;

  // check qualifiers
  logic                       tick_hit;
  logic                       add_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // execute only when the output register is free or being emptied
  assign ex_go = (state_r == S_EX) && (!out_valid_r || !out_stall);
  assign full  = (next_slot_r == CNT_W'(MAX_PROCESSES));

  // first live slot after the one served last, wrapping to the lowest live slot
  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      above[i] = (SLOT_W'(i) > last_r);
    end
    cand     = (|(live_r & above)) ? (live_r & above) : live_r;
    first_oh = cand & (~cand + {{(MAX_PROCESSES-1){1'b0}}, 1'b1});
    search_idx = '0;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if (first_oh[i]) begin
        search_idx = search_idx | SLOT_W'(i);
      end
    end
  end

  assign rd_need  = rdata_r[2*TW-1:TW];
  assign rd_run   = rdata_r[TW-1:0];
  assign run_inc  = rd_run + {{(TW-1){1'b0}}, 1'b1};
  assign finished = (run_inc >= rd_need);

  // execute step: result, write-back data and next control state
  always_comb begin
    live_nxt      = live_r;
    last_nxt      = last_r;
    next_slot_nxt = next_slot_r;
    mem_we        = 1'b0;
    wdata         = {need_r, {TW{1'b0}}};
    res           = '0;
    res.status    = ST_IDLE;
    if (op_r == OP_ADD) begin
      if (full) begin
        res.status = ST_FULL;
      end else begin
        // fresh process: need loaded, run time cleared
        mem_we                = ex_go;
        wdata                 = {need_r, {TW{1'b0}}};
        live_nxt[slot_r]      = 1'b1;
        next_slot_nxt         = next_slot_r + {{(CNT_W-1){1'b0}}, 1'b1};
        res.status            = ST_ADDED;
        res.process_id        = 4'(slot_r);
        res.need_time_out     = 8'(need_r);
      end
    end else if (found_r) begin
      // serve one slice and retire once run reaches need
      mem_we            = ex_go;
      wdata             = {rd_need, run_inc};
      last_nxt          = slot_r;
      res.status        = finished ? ST_FINISHED : ST_SERVED;
      res.process_id    = 4'(slot_r);
      res.run_time      = 8'(run_inc);
      res.need_time_out = 8'(rd_need);
      if (finished) begin
        live_nxt[slot_r] = 1'b0;
      end
    end
    res.all_done = ~|live_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        if (ex_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      last_r      <= SLOT_W'(MAX_PROCESSES - 1);
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ex_go) begin
        live_r      <= live_nxt;
        last_r      <= last_nxt;
        next_slot_r <= next_slot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.op;
      need_r <= TW'(in_data.need_time);
      if (in_data.op == OP_ADD) begin
        slot_r <= next_slot_r[SLOT_W-1:0];
      end else begin
        slot_r <= search_idx;
      end
      found_r <= |live_r;
    end
    if (ex_go) begin
      out_data_r <= res;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= wdata;
    end
    if (state_r == S_RD) begin
      rdata_r <= mem[slot_r];
    end
  end

  // checks
  assign tick_hit = ex_go && (op_r == OP_TICK) && found_r;
  assign add_hit  = ex_go && (op_r == OP_ADD) && !full;

  `RRPS_ASSERT_NOW(a_served_slot_live, tick_hit, live_r[slot_r])
  `RRPS_ASSERT_NEXT(a_finish_retires, tick_hit && finished, !live_r[slot_r])
  `RRPS_ASSERT_NEXT(a_add_advances, add_hit, next_slot_r == $past(next_slot_r) + 1'b1)
  `RRPS_ASSERT_NOW(a_count_bounded, 1'b1, next_slot_r <= CNT_W'(MAX_PROCESSES))

endmodule

@@ tb/round_robin_process_scheduler_tb.sv @@
`timescale 1ns / 100ps

import rrps_pkg::*;

// scoreboard: own copy of the slot table, queue of expected results
class slot_table_checker;
  localparam int NSLOTS = 16;

  bit [7:0]        need_tbl [NSLOTS];
  bit [7:0]        run_tbl  [NSLOTS];
  bit [NSLOTS-1:0] live;
  int              last_served;
  int              next_slot;
  int              errors;
  out_res_t        expected_results [$];

  function new();
    for (int k = 0; k < NSLOTS; k++) begin
      need_tbl[k] = '0;
      run_tbl[k]  = '0;
    end
    live        = '0;
    last_served = NSLOTS - 1;
    next_slot   = 0;
    errors      = 0;
  endfunction

  // work out the result of one accepted request and queue it
  function void note_request(in_req_t r);
    out_res_t   e;
    int         slot;
    bit         found;
    logic [7:0] rt;
    e     = '0;
    found = 1'b0;
    if (r.op == OP_ADD) begin
      if (next_slot >= NSLOTS) begin
        e.status = ST_FULL;
      end else begin
        need_tbl[next_slot] = r.need_time;
        run_tbl[next_slot]  = '0;
        live[next_slot]     = 1'b1;
        e.status            = ST_ADDED;
        e.process_id        = next_slot[3:0];
        e.need_time_out     = r.need_time;
        next_slot++;
      end
    end else begin
      e.status = ST_IDLE;
      for (int k = 1; k <= NSLOTS; k++) begin
        slot = (last_served + k) % NSLOTS;
        if (!found && live[slot]) begin
          found         = 1'b1;
          rt            = run_tbl[slot] + 8'd1;
          run_tbl[slot] = rt;
          last_served   = slot;
          e.status      = ST_SERVED;
          if (rt >= need_tbl[slot]) begin
            live[slot] = 1'b0;
            e.status   = ST_FINISHED;
          end
          e.process_id    = slot[3:0];
          e.run_time      = rt;
          e.need_time_out = need_tbl[slot];
        end
      end
    end
    e.all_done = (live == '0);
    expected_results.push_back(e);
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(out_res_t got);
    out_res_t e;
    if (expected_results.size() == 0) begin
      $error("result with nothing pending: status %0d id %0d", got.status, got.process_id);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (got.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, got.status);
      errors++;
    end
    if (got.process_id !== e.process_id) begin
      $error("process_id: expected %0d, got %0d", e.process_id, got.process_id);
      errors++;
    end
    if (got.run_time !== e.run_time) begin
      $error("run_time: expected %0d, got %0d", e.run_time, got.run_time);
      errors++;
    end
    if (got.need_time_out !== e.need_time_out) begin
      $error("need_time_out: expected %0d, got %0d", e.need_time_out, got.need_time_out);
      errors++;
    end
    if (got.all_done !== e.all_done) begin
      $error("all_done: expected %0d, got %0d", e.all_done, got.all_done);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_results.size();
  endfunction
endclass

module round_robin_process_scheduler_tb;

  localparam int N_RANDOM    = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 300;   // request count at which the receiver holds off
  localparam int HOLD_CYCLES = 250;
  localparam int QUIET_FROM  = 600;   // stretch of requests with no idling on either side
  localparam int QUIET_TO    = 800;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;

  slot_table_checker sb;
  int                requests_sent = 0;
  int                cycles = 0;

  round_robin_process_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side while inside the quiet stretch
  function automatic bit quiet_stretch();
    return requests_sent >= QUIET_FROM && requests_sent < QUIET_TO;
  endfunction

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("round_robin_process_scheduler_tb: FAIL");
      $finish;
    end
  end

  // request side monitor: every accepted request goes to the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
  end

  // result side monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stalls, one long hold-off counted here while the sender keeps going
  initial begin
    bit held;
    int hold_left;
    held      = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!held && requests_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet_stretch() && ($urandom_range(99) < 10);
      end
    end
  end

  // offer one request, with an occasional gap in front, and wait for acceptance
  task automatic send_request(logic op, logic [7:0] need);
    in_req_t r;
    int      gap;
    r.op        = op;
    r.need_time = need;
    if (!quiet_stretch() && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  initial begin
    logic       op;
    logic [7:0] need;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick on an empty table
    send_request(OP_TICK, 8'hff);
    // shortest need, served and finished at once
    send_request(OP_ADD, 8'd1);
    send_request(OP_TICK, 8'h00);
    send_request(OP_TICK, 8'h5a);
    // zero need finishes on its first tick with run time 1
    send_request(OP_ADD, 8'd0);
    send_request(OP_TICK, 8'h00);
    // largest need plus two short ones, ring order across three live slots
    send_request(OP_ADD, 8'd255);
    send_request(OP_ADD, 8'd2);
    send_request(OP_ADD, 8'd3);
    repeat (6) send_request(OP_TICK, 8'ha5);
    send_request(OP_ADD, 8'haa);
    send_request(OP_ADD, 8'h55);
    send_request(OP_TICK, 8'h00);

    // random mix: mostly ticks, adds until the table is full and then refused
    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(99) < 75) ? OP_TICK : OP_ADD;
      if ($urandom_range(99) < 70) need = 8'($urandom_range(1, 30));
      else need = 8'($urandom_range(0, 255));
      send_request(op, need);
    end
    in_valid <= 1'b0;

    // drain, then a few cycles more to catch anything stray
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("round_robin_process_scheduler_tb: PASS");
    end else begin
      $display("round_robin_process_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule
